[rtl/core/nfc_response_frame_parser_defines.svh]
// Assertion helpers used by the top-level parser. Both expect clk and rst in scope.
`ifndef NFC_RESPONSE_FRAME_PARSER_DEFINES_SVH
`define NFC_RESPONSE_FRAME_PARSER_DEFINES_SVH

// expr must hold at every edge outside reset
`define NFCRP_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("nfcrp check failed");

// cons must hold in the cycle after ante
`define NFCRP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nfcrp check failed");

`endif

[rtl/core/nfcrp_pkg.sv]
package nfcrp_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int CFG_IDX_W       = 2;

  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_COMMAND  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_FRAME_ID = 2'd2;

  localparam logic [7:0] EXPECTED_COMMAND_RST  = 8'd0;
  localparam logic [7:0] MAX_PAYLOAD_RST       = 8'd255;
  localparam logic [7:0] EXPECTED_FRAME_ID_RST = 8'd213;

  localparam logic [7:0] PREAMBLE    = 8'h00;
  localparam logic [7:0] START_CODE1 = 8'h00;
  localparam logic [7:0] START_CODE2 = 8'hFF;
  localparam logic [7:0] LEN_BIAS    = 8'd2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_READY = 2'd1,
    ST_INVALID   = 2'd2,
    ST_NO_SPACE  = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    status_t    status;
    logic [7:0] payload_count;
    logic       last;
  } result_t;

endpackage

[rtl/core/nfcrp_if.sv]
interface nfcrp_in_if;
  import nfcrp_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;
  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface nfcrp_out_if;
  import nfcrp_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  status_t    status;
  logic [7:0] payload_count;
  logic       last;
  modport source (output valid, output data_byte, output status, output payload_count,
                  output last, input ready);
  modport sink (input valid, input data_byte, input status, input payload_count,
                input last, output ready);
endinterface

interface nfcrp_cfg_if;
  import nfcrp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [7:0]           wdata;
  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

[rtl/core/nfcrp_front.sv]
module nfcrp_front (
  input  logic               clk,
  input  logic               rst,
  nfcrp_in_if.sink           rx,
  nfcrp_cfg_if.sink          cfg,
  input  logic               q_full,
  output logic               push,
  output nfcrp_pkg::result_t push_data
);
  import nfcrp_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_PRE, PH_SC1, PH_SC2, PH_LEN, PH_LCS,
    PH_TFI, PH_CMD, PH_DATA, PH_DCS, PH_POST
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] delivered_count, delivered_count_next;
  logic [7:0] expected_command, max_payload, expected_frame_id;
  logic [7:0] len_payload;
  logic       accept;
  logic       res_valid;
  logic       fin;
  status_t    fin_status;
  result_t    res;

  assign rx.ready  = !q_full;
  assign cfg.ready = 1'b1;
  assign accept    = rx.valid && rx.ready;
  assign len_payload = frame_length - LEN_BIAS;

  always_comb begin
    phase_next           = phase;
    running_sum_next     = running_sum;
    frame_length_next    = frame_length;
    bytes_left_next      = bytes_left;
    delivered_count_next = delivered_count;
    fin                  = 1'b0;
    fin_status           = ST_OK;
    res_valid            = 1'b0;
    res.data_byte        = rx.rx_byte;
    res.status           = ST_OK;
    res.payload_count    = delivered_count + 8'd1;
    res.last             = 1'b0;

    if (rx.frame_start) begin
      running_sum_next     = '0;
      frame_length_next    = '0;
      bytes_left_next      = '0;
      delivered_count_next = '0;
      if (!rx.rx_byte[0]) begin
        fin        = 1'b1;
        fin_status = ST_NOT_READY;
      end else begin
        phase_next = PH_PRE;
      end
    end else begin
      unique case (phase)
        PH_PRE: begin
          if (rx.rx_byte != PREAMBLE) begin
            fin = 1'b1; fin_status = ST_INVALID;
          end else phase_next = PH_SC1;
        end
        PH_SC1: begin
          if (rx.rx_byte != START_CODE1) begin
            fin = 1'b1; fin_status = ST_INVALID;
          end else phase_next = PH_SC2;
        end
        PH_SC2: begin
          if (rx.rx_byte != START_CODE2) begin
            fin = 1'b1; fin_status = ST_INVALID;
          end else phase_next = PH_LEN;
        end
        PH_LEN: begin
          frame_length_next = rx.rx_byte;
          phase_next        = PH_LCS;
        end
        PH_LCS: begin
          if (frame_length + rx.rx_byte != 8'd0) begin
            fin = 1'b1; fin_status = ST_INVALID;
          end else phase_next = PH_TFI;
        end
        PH_TFI: begin
          if (rx.rx_byte != expected_frame_id) begin
            fin = 1'b1; fin_status = ST_INVALID;
          end else begin
            running_sum_next = rx.rx_byte;
            phase_next       = PH_CMD;
          end
        end
        PH_CMD: begin
          if (rx.rx_byte != expected_command + 8'd1) begin
            fin = 1'b1; fin_status = ST_INVALID;
          end else begin
            running_sum_next = running_sum + rx.rx_byte;
            bytes_left_next  = len_payload;
            if (len_payload > max_payload) begin
              fin = 1'b1; fin_status = ST_NO_SPACE;
            end else begin
              phase_next = (len_payload == 8'd0) ? PH_DCS : PH_DATA;
            end
          end
        end
        PH_DATA: begin
          running_sum_next     = running_sum + rx.rx_byte;
          delivered_count_next = delivered_count + 8'd1;
          bytes_left_next      = bytes_left - 8'd1;
          if (bytes_left == 8'd1) phase_next = PH_DCS;
          res_valid = 1'b1;
        end
        PH_DCS: begin
          if (running_sum + rx.rx_byte != 8'd0) begin
            fin = 1'b1; fin_status = ST_INVALID;
          end else phase_next = PH_POST;
        end
        PH_POST: begin
          fin = 1'b1; fin_status = ST_OK;
        end
        default: phase_next = PH_IDLE;
      endcase
    end

    // final status: zero data, count so far, back to idle
    if (fin) begin
      phase_next        = PH_IDLE;
      res_valid         = 1'b1;
      res.data_byte     = '0;
      res.status        = fin_status;
      res.payload_count = delivered_count_next;
      res.last          = 1'b1;
    end
  end

  assign push      = accept && res_valid;
  assign push_data = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      running_sum     <= '0;
      frame_length    <= '0;
      bytes_left      <= '0;
      delivered_count <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      running_sum     <= running_sum_next;
      frame_length    <= frame_length_next;
      bytes_left      <= bytes_left_next;
      delivered_count <= delivered_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_command  <= EXPECTED_COMMAND_RST;
      max_payload       <= MAX_PAYLOAD_RST;
      expected_frame_id <= EXPECTED_FRAME_ID_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.reg_index)
        REG_EXPECTED_COMMAND:  expected_command  <= cfg.wdata;
        REG_MAX_PAYLOAD:       max_payload       <= cfg.wdata;
        REG_EXPECTED_FRAME_ID: expected_frame_id <= cfg.wdata;
        default: ;
      endcase
    end
  end

endmodule

[rtl/core/nfcrp_queue.sv]
module nfcrp_queue #(
  parameter int DEPTH = nfcrp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  nfcrp_pkg::result_t       push_data,
  output logic                     full,
  output logic [$clog2(DEPTH+1)-1:0] level,
  nfcrp_out_if.source              res
);
  import nfcrp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  result_t          mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic             pop;
  result_t          head;

  assign full  = (level == LVL_W'(DEPTH));
  assign pop   = res.valid && res.ready;
  assign head  = mem[rd_ptr];

  assign res.valid         = (level != '0);
  assign res.data_byte     = head.data_byte;
  assign res.status        = head.status;
  assign res.payload_count = head.payload_count;
  assign res.last          = head.last;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      priority if (push && !pop) level <= level + LVL_W'(1);
      else if (pop && !push)     level <= level - LVL_W'(1);
      else                       level <= level;
    end
  end

endmodule

[rtl/core/nfc_response_frame_parser.sv]
// Response frame parser for a contactless reader host link.
// Channels:
//   rx  - one received bus byte per beat; frame_start marks the ready status
//         byte that opens a read.
//   res - payload bytes (last=0) and one final status beat (last=1) per read:
//         ok, not ready, invalid frame or no space, with the payload count.
//   cfg - register writes: 0 expected command, 1 max payload, 2 frame id.
//         Always ready; write only while the parser is idle.
// Throughput: one rx beat per cycle while the queue is not full. The front
// parser takes a byte, classifies it against the frame phase and pushes any
// result into a QUEUE_DEPTH-entry queue; the queue head drives res directly.
// Latency: a result is on res the cycle after the byte that caused it when
// the queue is empty; behind queued results it waits its turn.
// When res stalls the queue fills; rx.ready drops only while the queue is
// full, so up to QUEUE_DEPTH results are held and header bytes (which give
// no result) still flow only while space remains.
// Reset: the parser goes idle, the queue empties and the registers take
// their defaults (command 0, max payload 255, frame id 213).
module nfc_response_frame_parser #(
  parameter int QUEUE_DEPTH = nfcrp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  nfcrp_in_if.sink    rx,
  nfcrp_cfg_if.sink   cfg,
  nfcrp_out_if.source res
);
  import nfcrp_pkg::*;

  `include "nfc_response_frame_parser_defines.svh"

  localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

  logic             push;
  logic             q_full;
  result_t          push_data;
  logic [LVL_W-1:0] level;

  nfcrp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .cfg       (cfg),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  nfcrp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .level     (level),
    .res       (res)
  );

  `NFCRP_ASSERT_ALWAYS(a_level_bound, level <= LVL_W'(QUEUE_DEPTH))
  `NFCRP_ASSERT_ALWAYS(a_payload_ok, !(res.valid && !res.last) || res.status == ST_OK)
  `NFCRP_ASSERT_ALWAYS(a_final_zero, !(res.valid && res.last) || res.data_byte == 8'd0)
  `NFCRP_ASSERT_NEXT(a_not_ready, rx.valid && rx.ready && rx.frame_start && !rx.rx_byte[0], res.valid && level != '0)

endmodule

[tb/tb_nfc_response_frame_parser.sv]
module tb_nfc_response_frame_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import nfcrp_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 120;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } rx_beat_t;

  typedef enum logic [3:0] {
    P_IDLE, P_PRE, P_SC1, P_SC2, P_LEN, P_LCS, P_TFI, P_CMD, P_DATA, P_DCS, P_POST
  } parse_phase_t;

  typedef enum int {
    FK_GOOD, FK_NOT_READY, FK_BAD_HEADER, FK_BAD_CHECKSUM, FK_CUT, FK_NOISE
  } frame_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  nfcrp_in_if  rx_if ();
  nfcrp_out_if res_if ();
  nfcrp_cfg_if cfg_if ();

  nfc_response_frame_parser i_dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_if),
    .cfg (cfg_if),
    .res (res_if)
  );

  always #10 clk = ~clk;

  // register mirror
  logic [7:0] cfg_command     = EXPECTED_COMMAND_RST;
  logic [7:0] cfg_max_payload = MAX_PAYLOAD_RST;
  logic [7:0] cfg_frame_id    = EXPECTED_FRAME_ID_RST;

  // parser state as predicted
  parse_phase_t pp_phase     = P_IDLE;
  logic [7:0]   pp_sum       = 8'd0;
  logic [7:0]   pp_length    = 8'd0;
  logic [7:0]   pp_left      = 8'd0;
  logic [7:0]   pp_delivered = 8'd0;

  rx_beat_t rx_pending[$];
  result_t  expected_results[$];

  int mismatch_count = 0;
  int rx_accepted    = 0;
  int stim_items     = 0;
  int cycle_count    = 0;
  int burst_left     = 0;
  int gap_left       = 0;
  int hold_left      = 0;
  int hold_count     = 0;
  int stall_mode     = 0;
  int mode_timer     = 0;
  result_t got_result;
  result_t want_result;

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) $display("ERROR at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic void close_frame(input status_t st);
    expected_results.push_back(result_t'{data_byte: 8'h00, status: st,
                                         payload_count: pp_delivered, last: 1'b1});
    pp_phase = P_IDLE;
  endfunction

  function automatic void predict_frame_byte(input logic [7:0] b, input logic start);
    logic [7:0] chk;
    logic [7:0] cmd_code;
    cmd_code = cfg_command + 8'd1;
    if (start) begin
      pp_sum       = 8'd0;
      pp_length    = 8'd0;
      pp_left      = 8'd0;
      pp_delivered = 8'd0;
      if (!b[0]) close_frame(ST_NOT_READY);
      else pp_phase = P_PRE;
      return;
    end
    case (pp_phase)
      P_PRE: begin
        if (b != PREAMBLE) close_frame(ST_INVALID);
        else pp_phase = P_SC1;
      end
      P_SC1: begin
        if (b != START_CODE1) close_frame(ST_INVALID);
        else pp_phase = P_SC2;
      end
      P_SC2: begin
        if (b != START_CODE2) close_frame(ST_INVALID);
        else pp_phase = P_LEN;
      end
      P_LEN: begin
        pp_length = b;
        pp_phase  = P_LCS;
      end
      P_LCS: begin
        chk = pp_length + b;
        if (chk != 8'd0) close_frame(ST_INVALID);
        else pp_phase = P_TFI;
      end
      P_TFI: begin
        if (b != cfg_frame_id) close_frame(ST_INVALID);
        else begin
          pp_sum   = b;
          pp_phase = P_CMD;
        end
      end
      P_CMD: begin
        if (b != cmd_code) close_frame(ST_INVALID);
        else begin
          pp_sum  = pp_sum + b;
          pp_left = pp_length - LEN_BIAS;
          if (pp_left > cfg_max_payload) close_frame(ST_NO_SPACE);
          else pp_phase = (pp_left == 8'd0) ? P_DCS : P_DATA;
        end
      end
      P_DATA: begin
        pp_sum       = pp_sum + b;
        pp_delivered = pp_delivered + 8'd1;
        pp_left      = pp_left - 8'd1;
        if (pp_left == 8'd0) pp_phase = P_DCS;
        expected_results.push_back(result_t'{data_byte: b, status: ST_OK,
                                             payload_count: pp_delivered, last: 1'b0});
      end
      P_DCS: begin
        chk = pp_sum + b;
        if (chk != 8'd0) close_frame(ST_INVALID);
        else pp_phase = P_POST;
      end
      P_POST: close_frame(ST_OK);
      default: pp_phase = P_IDLE;
    endcase
  endfunction

  // rx driver: bursts with random gaps, valid held until the beat is taken
  always @(posedge clk) begin
    if (rst) begin
      rx_if.valid       <= 1'b0;
      rx_if.rx_byte     <= 8'h00;
      rx_if.frame_start <= 1'b0;
    end else begin
      if (rx_if.valid && rx_if.ready) begin
        predict_frame_byte(rx_if.rx_byte, rx_if.frame_start);
        void'(rx_pending.pop_front());
        rx_accepted++;
      end
      if (!(rx_if.valid && !rx_if.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          rx_if.valid <= 1'b0;
        end else if (rx_pending.size() > 0) begin
          rx_if.valid       <= 1'b1;
          rx_if.rx_byte     <= rx_pending[0].rx_byte;
          rx_if.frame_start <= rx_pending[0].frame_start;
          if (burst_left > 0) begin
            burst_left--;
          end else if ($urandom_range(0, 9) == 0) begin
            burst_left = 100;
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 5);
          end
        end else begin
          rx_if.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off so the result queue fills and rx stalls
  always @(posedge clk) begin
    if (rst) begin
      hold_left  <= 0;
      hold_count <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_count < 2 && rx_accepted >= (hold_count + 1) * 300) begin
      hold_left  <= HOLD_CYCLES;
      hold_count <= hold_count + 1;
    end
  end

  // result monitor and ready pattern
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
      stall_mode   <= 0;
      mode_timer   <= 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        got_result = result_t'{data_byte: res_if.data_byte, status: res_if.status,
                               payload_count: res_if.payload_count, last: res_if.last};
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing expected: %p", got_result));
        end else begin
          want_result = expected_results.pop_front();
          if (got_result.data_byte !== want_result.data_byte)
            report_mismatch($sformatf("data_byte %02h, expected %02h",
                                      got_result.data_byte, want_result.data_byte));
          if (got_result.status !== want_result.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      got_result.status, want_result.status));
          if (got_result.payload_count !== want_result.payload_count)
            report_mismatch($sformatf("payload_count %0d, expected %0d",
                                      got_result.payload_count, want_result.payload_count));
          if (got_result.last !== want_result.last)
            report_mismatch($sformatf("last %0b, expected %0b",
                                      got_result.last, want_result.last));
        end
      end
      if (mode_timer == 149) begin
        mode_timer <= 0;
        stall_mode <= $urandom_range(0, 3);
      end else begin
        mode_timer <= mode_timer + 1;
      end
      if (hold_left != 0) begin
        res_if.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0:       res_if.ready <= 1'b1;
          1:       res_if.ready <= $urandom_range(0, 1);
          2:       res_if.ready <= ($urandom_range(0, 3) == 0);
          default: res_if.ready <= (mode_timer[2:0] != 3'd0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("nfc_response_frame_parser: mismatch");
      $finish;
    end
  end

  function automatic logic [7:0] flip_byte(input logic [7:0] v);
    return v ^ 8'($urandom_range(1, 255));
  endfunction

  function automatic void push_rx_beat(input logic [7:0] b, input logic s, input bit counted);
    rx_pending.push_back(rx_beat_t'{rx_byte: b, frame_start: s});
    if (counted) stim_items++;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    @(posedge clk);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wdata     <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      REG_EXPECTED_COMMAND:  cfg_command     = value;
      REG_MAX_PAYLOAD:       cfg_max_payload = value;
      REG_EXPECTED_FRAME_ID: cfg_frame_id    = value;
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (rx_pending.size() != 0 || rx_if.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic int pick_payload_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6 && cfg_max_payload <= 60) return cfg_max_payload;
    if (r < 10 && cfg_max_payload < 60) return cfg_max_payload + 1;
    // LEN of 0 or 1 wraps to a huge payload length
    if (r < 12) return $urandom_range(254, 255);
    if (r < 30) return $urandom_range(7, 40);
    return $urandom_range(0, 6);
  endfunction

  function automatic frame_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return FK_GOOD;
    if (r < 62) return FK_NOT_READY;
    if (r < 77) return FK_BAD_HEADER;
    if (r < 85) return FK_BAD_CHECKSUM;
    if (r < 93) return FK_CUT;
    return FK_NOISE;
  endfunction

  task automatic queue_frame(input frame_kind_t kind, input int plen);
    logic [7:0] fb[$];
    logic [7:0] stat;
    logic [7:0] lenb;
    logic [7:0] cmd_code;
    logic [7:0] dsum;
    logic [7:0] d;
    int         cut;
    int         pos;
    int         extra;
    if (kind == FK_NOISE) begin
      repeat ($urandom_range(1, 3)) push_rx_beat(8'($urandom), 1'b0, 1'b0);
      return;
    end
    stat     = 8'($urandom);
    stat[0]  = 1'b1;
    lenb     = 8'(plen) + LEN_BIAS;
    cmd_code = cfg_command + 8'd1;
    fb.push_back(stat);
    fb.push_back(PREAMBLE);
    fb.push_back(START_CODE1);
    fb.push_back(START_CODE2);
    fb.push_back(lenb);
    fb.push_back(8'd0 - lenb);
    fb.push_back(cfg_frame_id);
    fb.push_back(cmd_code);
    dsum = cfg_frame_id + cmd_code;
    for (int i = 0; i < plen; i++) begin
      d    = 8'($urandom);
      dsum = dsum + d;
      fb.push_back(d);
    end
    fb.push_back(8'd0 - dsum);
    fb.push_back(8'($urandom));
    cut = fb.size();
    // no room: the frame ends at the command byte
    if (plen > cfg_max_payload) cut = 8;
    case (kind)
      FK_NOT_READY: begin
        fb[0] = fb[0] & 8'hFE;
        cut   = 1;
      end
      FK_BAD_HEADER: begin
        pos     = $urandom_range(1, 7);
        fb[pos] = flip_byte(fb[pos]);
        cut     = pos + 1;
      end
      FK_BAD_CHECKSUM: begin
        if (plen <= cfg_max_payload) fb[8 + plen] = flip_byte(fb[8 + plen]);
      end
      FK_CUT: cut = $urandom_range(1, cut - 1);
      default: ;
    endcase
    for (int i = 0; i < cut; i++) push_rx_beat(fb[i], (i == 0), 1'b1);
    if (kind != FK_CUT) begin
      extra = $urandom_range(0, 2);
      for (int i = cut; i < fb.size() && i < cut + extra; i++)
        push_rx_beat(fb[i], 1'b0, 1'b0);
    end
  endtask

  task automatic run_phase(input logic [7:0] cmd, input logic [7:0] max_len,
                           input logic [7:0] fid, input int target);
    write_reg(REG_EXPECTED_COMMAND, cmd);
    write_reg(REG_MAX_PAYLOAD, max_len);
    write_reg(REG_EXPECTED_FRAME_ID, fid);
    stim_items = 0;
    while (stim_items < target) queue_frame(pick_kind(), pick_payload_len());
    // close with a not-ready read so the parser ends idle
    push_rx_beat(8'h00, 1'b1, 1'b1);
    wait_idle();
  endtask

  initial begin
    rx_if.valid       = 1'b0;
    rx_if.rx_byte     = 8'h00;
    rx_if.frame_start = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.reg_index  = REG_EXPECTED_COMMAND;
    cfg_if.wdata      = 8'h00;
    res_if.ready      = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed, reset register values
    push_rx_beat(8'hAB, 1'b0, 1'b1);   // idle byte, dropped
    push_rx_beat(8'hFE, 1'b1, 1'b1);   // not ready
    push_rx_beat(8'hFF, 1'b1, 1'b1);   // bad preamble
    push_rx_beat(8'hFF, 1'b0, 1'b1);
    push_rx_beat(8'h01, 1'b1, 1'b1);   // wrong frame id
    push_rx_beat(8'h00, 1'b0, 1'b1);
    push_rx_beat(8'h00, 1'b0, 1'b1);
    push_rx_beat(8'hFF, 1'b0, 1'b1);
    push_rx_beat(8'h03, 1'b0, 1'b1);
    push_rx_beat(8'hFD, 1'b0, 1'b1);
    push_rx_beat(8'h00, 1'b0, 1'b1);
    push_rx_beat(8'h01, 1'b1, 1'b1);   // abandoned by a restart
    push_rx_beat(8'h00, 1'b0, 1'b1);
    push_rx_beat(8'hFF, 1'b1, 1'b1);   // good frame, one payload byte
    push_rx_beat(8'h00, 1'b0, 1'b1);
    push_rx_beat(8'h00, 1'b0, 1'b1);
    push_rx_beat(8'hFF, 1'b0, 1'b1);
    push_rx_beat(8'h03, 1'b0, 1'b1);
    push_rx_beat(8'hFD, 1'b0, 1'b1);
    push_rx_beat(8'hD5, 1'b0, 1'b1);
    push_rx_beat(8'h01, 1'b0, 1'b1);
    push_rx_beat(8'hFF, 1'b0, 1'b1);
    push_rx_beat(8'h2B, 1'b0, 1'b1);
    push_rx_beat(8'hA5, 1'b0, 1'b1);
    wait_idle();

    run_phase(8'h4A, 8'd255, 8'hD5, 175);
    run_phase(8'hFF, 8'd0, 8'h00, 175);
    run_phase(8'h00, 8'd8, 8'hFF, 175);
    run_phase(8'($urandom), 8'($urandom_range(0, 20)), 8'($urandom), 175);
    run_phase(8'($urandom), 8'd255, 8'hD5, 175);

    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("nfc_response_frame_parser: match");
    end else begin
      $display("nfc_response_frame_parser: mismatch");
    end
    $finish;
  end

endmodule
